[rtl/q8sj_pkg.sv]
// ----------------------------------------------------------------------------
// q8sj_pkg: shared types, constants and helpers for the quad8 evaluator
// Request and result payloads, function codes and fixed-point helpers.
// ----------------------------------------------------------------------------
package q8sj_pkg;

   // Function codes of a request
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_EVAL = 1'b1;

   // Element geometry
   localparam int NODES  = 8;
   localparam int NODE_W = 3;
   localparam logic [NODE_W-1:0] LAST_NODE = 3'd7;

   // One in Q4.14 and in Q4.28
   localparam logic signed [17:0] ONE14 = 18'sd16384;
   localparam logic signed [31:0] ONE28 = 32'sd268435456;

   typedef struct packed {
      logic               func;
      logic [2:0]         node_index;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic signed [15:0] xi;
      logic signed [15:0] eta;
   } q8sj_req_type;

   typedef struct packed {
      logic [2:0]         out_node;
      logic signed [31:0] shape_value;
      logic signed [31:0] dn_dx;
      logic signed [31:0] dn_dy;
      logic signed [31:0] jacobian_det;
      logic signed [31:0] global_x;
      logic signed [31:0] global_y;
      logic               singular;
      logic               last;
   } q8sj_rsp_type;

   // Round to nearest, ties upward, dropping n fraction bits (n >= 1)
   function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                    input int n);
      logic signed [63:0] half;
      half = 64'sd1 <<< (n - 1);
      return (v + half) >>> n;
   endfunction

   // Saturate to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] res;
      if (v > 64'sd2147483647) begin
         res = 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         res = 32'sh80000000;
      end else begin
         res = v[31:0];
      end
      return res;
   endfunction

endpackage

[rtl/q8sj_chan_if.sv]
// ----------------------------------------------------------------------------
// q8sj_chan_if: valid/ready channel
// Carries one payload per handshake; source drives valid and data.
// ----------------------------------------------------------------------------
interface q8sj_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[rtl/quad8_shape_jacobian_eval.sv]
// ----------------------------------------------------------------------------
// quad8_shape_jacobian_eval: eight-node serendipity element evaluator
// Shape values, global derivatives, Jacobian determinant and mapped point.
// ----------------------------------------------------------------------------
// Usage
//   req_if carries load and evaluate requests; rsp_if carries result rows.
//   A load request writes one node's x,y into the node memory and produces
//   no row. An evaluate request produces eight rows, node 0 to 7, the last
//   one marked.
//   The two bit-serial dividers, one quotient bit per cycle, take most of the
//   time of an evaluation; the node pass and the Jacobian come before them.
//   A singular element skips the dividers. One request is worked on at a
//   time.
//   Reset clears the node valid bits, so every node reads as zero until it
//   is loaded, and empties the result register.
//   A stalled receiver holds the pending row; the next row is worked out
//   but waits until the result register is free. The block takes new
//   requests while the last row of an evaluation still waits.
// ----------------------------------------------------------------------------
module quad8_shape_jacobian_eval #(
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   q8sj_chan_if.sink   req_if,
   q8sj_chan_if.source rsp_if
);

   localparam int DIV_SHIFT = 2 * COORD_FRAC_BITS - 16;
   localparam int SHAPE_SH  = 44 - COORD_FRAC_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_PREP, S_N1, S_N2, S_N3, S_N4, S_N5,
      S_J1, S_J2, S_J3, S_R1, S_R2, S_RW, S_RO
   } state_type;

   state_type state_ff;
   logic [q8sj_pkg::NODE_W-1:0] cnt_ff;

   // Node memory and valid bits
   logic [63:0] node_mem [q8sj_pkg::NODES];
   logic [q8sj_pkg::NODES-1:0] node_vld_ff;
   logic [63:0] rd_ff;
   logic        rd_vld_ff;

   // Local point
   logic signed [15:0] s_ff, t_ff;
   logic signed [31:0] s2_ff, t2_ff;

   // Node pass pipeline
   logic signed [37:0] m1_ff;
   logic signed [35:0] gxi_ff, get_ff;
   logic signed [48:0] nq_ff;
   logic signed [20:0] dxi_ff, deta_ff;
   logic signed [29:0] n24_ff;
   logic signed [52:0] pa_ff, pb_ff, pc_ff, pd_ff;
   logic signed [61:0] pgx_ff, pgy_ff;
   logic signed [63:0] acc_a_ff, acc_b_ff, acc_c_ff, acc_d_ff, acc_gx_ff, acc_gy_ff;

   // Per-node rows kept for the output pass
   logic signed [20:0] dxi_row_ff  [q8sj_pkg::NODES];
   logic signed [20:0] deta_row_ff [q8sj_pkg::NODES];
   logic signed [31:0] shape_row_ff[q8sj_pkg::NODES];

   // Jacobian
   logic signed [31:0] j00_ff, j01_ff, j10_ff, j11_ff, gxo_ff, gyo_ff, det_out_ff;
   logic signed [63:0] dp1_ff, dp2_ff, det_ff;
   logic signed [52:0] u1_ff, u2_ff, v1_ff, v2_ff;

   // Result register
   logic                   rsp_valid_ff;
   q8sj_pkg::q8sj_rsp_type rsp_data_ff;

   logic req_acc;
   logic slot_free;
   logic row_load;
   assign req_acc   = req_if.valid && (state_ff == S_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_if.ready;
   assign row_load  = (state_ff == S_RO) && slot_free;

   // Corner and midside factors
   logic signed [17:0] sp, sm, tp, tm;
   logic signed [19:0] s20, t20;
   assign s20 = 20'(s_ff);
   assign t20 = 20'(t_ff);
   assign sp  = q8sj_pkg::ONE14 + 18'(s_ff);
   assign sm  = q8sj_pkg::ONE14 - 18'(s_ff);
   assign tp  = q8sj_pkg::ONE14 + 18'(t_ff);
   assign tm  = q8sj_pkg::ONE14 - 18'(t_ff);

   logic signed [18:0] a1, a2;
   logic signed [19:0] g2, h2;
   logic signed [31:0] a3, g1, h1;
   always_comb begin
      case (cnt_ff)
         3'd0: begin
            a1 = 19'(sp); a2 = 19'(tp);
            a3 = 32'(s20 + t20 - 20'(q8sj_pkg::ONE14));
            g1 = 32'(tp); g2 = 20'sd2 * s20 + t20;
            h1 = 32'(sp); h2 = 20'sd2 * t20 + s20;
         end
         3'd1: begin
            a1 = 19'(sm); a2 = 19'(tp);
            a3 = 32'(t20 - s20 - 20'(q8sj_pkg::ONE14));
            g1 = 32'(tp); g2 = 20'sd2 * s20 - t20;
            h1 = 32'(sm); h2 = 20'sd2 * t20 - s20;
         end
         3'd2: begin
            a1 = 19'(sm); a2 = 19'(tm);
            a3 = 32'(-s20 - t20 - 20'(q8sj_pkg::ONE14));
            g1 = 32'(tm); g2 = 20'sd2 * s20 + t20;
            h1 = 32'(sm); h2 = 20'sd2 * t20 + s20;
         end
         3'd3: begin
            a1 = 19'(sp); a2 = 19'(tm);
            a3 = 32'(s20 - t20 - 20'(q8sj_pkg::ONE14));
            g1 = 32'(tm); g2 = 20'sd2 * s20 - t20;
            h1 = 32'(sp); h2 = 20'sd2 * t20 - s20;
         end
         3'd4: begin
            a1 = 19'(tp); a2 = 19'sd2; a3 = s2_ff;
            g1 = 32'(tp); g2 = -20'sd4 * s20;
            h1 = s2_ff;   h2 = 20'sd2;
         end
         3'd5: begin
            a1 = 19'(sm); a2 = 19'sd2; a3 = t2_ff;
            g1 = t2_ff;   g2 = -20'sd2;
            h1 = 32'(sm); h2 = -20'sd4 * t20;
         end
         3'd6: begin
            a1 = 19'(tm); a2 = 19'sd2; a3 = s2_ff;
            g1 = 32'(tm); g2 = -20'sd4 * s20;
            h1 = s2_ff;   h2 = -20'sd2;
         end
         default: begin
            a1 = 19'(sp); a2 = 19'sd2; a3 = t2_ff;
            g1 = t2_ff;   g2 = 20'sd2;
            h1 = 32'(sp); h2 = -20'sd4 * t20;
         end
      endcase
   end

   // Multipliers of the node pass
   logic signed [37:0] m1_in;
   logic signed [51:0] gxi_w, get_w;
   logic signed [69:0] nq_w;
   logic signed [31:0] x_node, y_node;
   logic signed [52:0] pa_w, pb_w, pc_w, pd_w;
   logic signed [61:0] pgx_w, pgy_w;
   assign m1_in  = a1 * a2;
   assign gxi_w  = g1 * g2;
   assign get_w  = h1 * h2;
   assign nq_w   = m1_ff * a3;
   assign x_node = rd_vld_ff ? $signed(rd_ff[63:32]) : 32'sd0;
   assign y_node = rd_vld_ff ? $signed(rd_ff[31:0])  : 32'sd0;
   assign pa_w   = dxi_ff * x_node;
   assign pb_w   = dxi_ff * y_node;
   assign pc_w   = deta_ff * x_node;
   assign pd_w   = deta_ff * y_node;
   assign pgx_w  = n24_ff * x_node;
   assign pgy_w  = n24_ff * y_node;

   // Multipliers of the Jacobian and output pass
   logic signed [63:0] dp1_w, dp2_w;
   logic signed [52:0] u1_w, u2_w, v1_w, v2_w;
   logic signed [53:0] numx_w, numy_w;
   assign dp1_w  = j00_ff * j11_ff;
   assign dp2_w  = j01_ff * j10_ff;
   assign u1_w   = j11_ff * dxi_row_ff[cnt_ff];
   assign u2_w   = j01_ff * deta_row_ff[cnt_ff];
   assign v1_w   = j00_ff * deta_row_ff[cnt_ff];
   assign v2_w   = j10_ff * dxi_row_ff[cnt_ff];
   assign numx_w = 54'(u1_ff) - 54'(u2_ff);
   assign numy_w = 54'(v1_ff) - 54'(v2_ff);

   // Dividers for dN/dx and dN/dy
   logic               div_start;
   logic               divx_idle, divy_idle;
   logic signed [31:0] divx_quo, divy_quo;
   logic               singular;
   assign singular  = (det_ff == 64'sd0);
   assign div_start = (state_ff == S_R2) && !singular;

   q8sj_div #(.SHIFT(DIV_SHIFT)) u_div_x (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (64'(numx_w)),
      .den   (det_ff),
      .idle  (divx_idle),
      .quo   (divx_quo)
   );

   q8sj_div #(.SHIFT(DIV_SHIFT)) u_div_y (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (64'(numy_w)),
      .den   (det_ff),
      .idle  (divy_idle),
      .quo   (divy_quo)
   );

   // Node memory: write on load, read the current node every cycle
   always_ff @(posedge clock) begin
      if (req_acc && (req_if.data.func == q8sj_pkg::FUNC_LOAD)) begin
         node_mem[req_if.data.node_index] <= {req_if.data.coord_x, req_if.data.coord_y};
      end
      rd_ff     <= node_mem[cnt_ff];
      rd_vld_ff <= node_vld_ff[cnt_ff];
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         node_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // load a new row, else drop the row once taken
         rsp_valid_ff <= row_load || (rsp_valid_ff && !rsp_if.ready);
         case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  if (req_if.data.func == q8sj_pkg::FUNC_LOAD) begin
                     node_vld_ff[req_if.data.node_index] <= 1'b1;
                  end else begin
                     s_ff     <= req_if.data.xi;
                     t_ff     <= req_if.data.eta;
                     cnt_ff   <= '0;
                     state_ff <= S_PREP;
                  end
               end
            end
            S_PREP: begin
               s2_ff     <= q8sj_pkg::ONE28 - s_ff * s_ff;
               t2_ff     <= q8sj_pkg::ONE28 - t_ff * t_ff;
               acc_a_ff  <= '0;
               acc_b_ff  <= '0;
               acc_c_ff  <= '0;
               acc_d_ff  <= '0;
               acc_gx_ff <= '0;
               acc_gy_ff <= '0;
               state_ff  <= S_N1;
            end
            S_N1: begin
               m1_ff    <= m1_in;
               gxi_ff   <= gxi_w[35:0];
               get_ff   <= get_w[35:0];
               state_ff <= S_N2;
            end
            S_N2: begin
               nq_ff    <= nq_w[48:0];
               dxi_ff   <= 21'(q8sj_pkg::rnd_shift(64'(gxi_ff), 14));
               deta_ff  <= 21'(q8sj_pkg::rnd_shift(64'(get_ff), 14));
               state_ff <= S_N3;
            end
            S_N3: begin
               n24_ff <= 30'(q8sj_pkg::rnd_shift(64'(nq_ff), 20));
               shape_row_ff[cnt_ff] <=
                  q8sj_pkg::sat32(q8sj_pkg::rnd_shift(64'(nq_ff), SHAPE_SH));
               dxi_row_ff[cnt_ff]  <= dxi_ff;
               deta_row_ff[cnt_ff] <= deta_ff;
               pa_ff    <= pa_w;
               pb_ff    <= pb_w;
               pc_ff    <= pc_w;
               pd_ff    <= pd_w;
               state_ff <= S_N4;
            end
            S_N4: begin
               pgx_ff   <= pgx_w;
               pgy_ff   <= pgy_w;
               acc_a_ff <= acc_a_ff + 64'(pa_ff);
               acc_b_ff <= acc_b_ff + 64'(pb_ff);
               acc_c_ff <= acc_c_ff + 64'(pc_ff);
               acc_d_ff <= acc_d_ff + 64'(pd_ff);
               state_ff <= S_N5;
            end
            S_N5: begin
               acc_gx_ff <= acc_gx_ff + 64'(pgx_ff);
               acc_gy_ff <= acc_gy_ff + 64'(pgy_ff);
               cnt_ff    <= cnt_ff + 1'b1;
               state_ff  <= (cnt_ff == q8sj_pkg::LAST_NODE) ? S_J1 : S_N1;
            end
            S_J1: begin
               j00_ff   <= q8sj_pkg::sat32(q8sj_pkg::rnd_shift(acc_a_ff, 16));
               j01_ff   <= q8sj_pkg::sat32(q8sj_pkg::rnd_shift(acc_b_ff, 16));
               j10_ff   <= q8sj_pkg::sat32(q8sj_pkg::rnd_shift(acc_c_ff, 16));
               j11_ff   <= q8sj_pkg::sat32(q8sj_pkg::rnd_shift(acc_d_ff, 16));
               gxo_ff   <= q8sj_pkg::sat32(q8sj_pkg::rnd_shift(acc_gx_ff, 24));
               gyo_ff   <= q8sj_pkg::sat32(q8sj_pkg::rnd_shift(acc_gy_ff, 24));
               state_ff <= S_J2;
            end
            S_J2: begin
               dp1_ff   <= dp1_w;
               dp2_ff   <= dp2_w;
               state_ff <= S_J3;
            end
            S_J3: begin
               det_ff   <= dp1_ff - dp2_ff;
               cnt_ff   <= '0;
               state_ff <= S_R1;
            end
            S_R1: begin
               det_out_ff <= q8sj_pkg::sat32(q8sj_pkg::rnd_shift(det_ff, COORD_FRAC_BITS));
               u1_ff      <= u1_w;
               u2_ff      <= u2_w;
               v1_ff      <= v1_w;
               v2_ff      <= v2_w;
               state_ff   <= S_R2;
            end
            S_R2: begin
               state_ff <= S_RW;
            end
            S_RW: begin
               if (divx_idle && divy_idle) begin
                  state_ff <= S_RO;
               end
            end
            S_RO: begin
               // hold until the result register is free
               if (slot_free) begin
                  rsp_data_ff.out_node     <= cnt_ff;
                  rsp_data_ff.shape_value  <= shape_row_ff[cnt_ff];
                  rsp_data_ff.dn_dx        <= singular ? 32'sd0 : divx_quo;
                  rsp_data_ff.dn_dy        <= singular ? 32'sd0 : divy_quo;
                  rsp_data_ff.jacobian_det <= det_out_ff;
                  rsp_data_ff.global_x     <= gxo_ff;
                  rsp_data_ff.global_y     <= gyo_ff;
                  rsp_data_ff.singular     <= singular;
                  rsp_data_ff.last         <= (cnt_ff == q8sj_pkg::LAST_NODE);
                  if (cnt_ff == q8sj_pkg::LAST_NODE) begin
                     state_ff <= S_IDLE;
                  end else begin
                     cnt_ff   <= cnt_ff + 1'b1;
                     state_ff <= S_R1;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_if.ready = (state_ff == S_IDLE);
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

endmodule

[rtl/q8sj_div.sv]
// ----------------------------------------------------------------------------
// q8sj_div: bit-serial signed divider
// round(num * 2^SHIFT / den), ties away from zero, saturated to 32 bits.
// One quotient bit per cycle, 64 + SHIFT iterations and a finishing step.
// ----------------------------------------------------------------------------
module q8sj_div #(
   parameter int SHIFT = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] num,
   input  logic signed [63:0] den,
   output logic               idle,
   output logic signed [31:0] quo
);

   localparam int ITERS = 64 + SHIFT;
   localparam int CNT_W = $clog2(ITERS);

   typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} div_state_type;

   div_state_type      state_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [63:0]        n_ff;
   logic [63:0]        d_ff;
   logic [63:0]        r_ff;
   logic [31:0]        q_ff;
   logic               ovf_ff;
   logic               neg_ff;
   logic signed [31:0] quo_ff;

   // One restoring step
   logic [63:0] r_sh;
   logic        ge;
   logic [63:0] r_in;
   logic [32:0] q_sh;
   logic [31:0] q_in;
   assign r_sh = {r_ff[62:0], n_ff[63]};
   assign ge   = (r_sh >= d_ff);
   assign r_in = ge ? (r_sh - d_ff) : r_sh;
   assign q_sh = {q_ff, ge};
   assign q_in = q_sh[32] ? 32'hffffffff : q_sh[31:0];

   // Final rounding and saturation
   logic        rnd_up;
   logic [32:0] q_fin;
   logic [32:0] lim;
   logic [32:0] q_sat;
   logic [31:0] quo_in;
   assign rnd_up = !ovf_ff && (r_ff >= (d_ff - r_ff));
   assign q_fin  = {1'b0, q_ff} + 33'(rnd_up);
   assign lim    = neg_ff ? 33'h080000000 : 33'h07fffffff;
   assign q_sat  = (ovf_ff || (q_fin > lim)) ? lim : q_fin;
   assign quo_in = neg_ff ? (32'd0 - q_sat[31:0]) : q_sat[31:0];

   // Sequence the iterations
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
      end else begin
         case (state_ff)
            D_IDLE: begin
               if (start) begin
                  n_ff     <= num[63] ? (64'd0 - num) : num;
                  d_ff     <= den[63] ? (64'd0 - den) : den;
                  neg_ff   <= num[63] ^ den[63];
                  r_ff     <= '0;
                  q_ff     <= '0;
                  ovf_ff   <= 1'b0;
                  cnt_ff   <= '0;
                  state_ff <= D_RUN;
               end
            end
            D_RUN: begin
               r_ff   <= r_in;
               q_ff   <= q_in;
               ovf_ff <= ovf_ff | q_sh[32];
               n_ff   <= {n_ff[62:0], 1'b0};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(ITERS - 1)) begin
                  state_ff <= D_FIN;
               end
            end
            D_FIN: begin
               quo_ff   <= quo_in;
               state_ff <= D_IDLE;
            end
            default: begin
               state_ff <= D_IDLE;
            end
         endcase
      end
   end

   assign idle = (state_ff == D_IDLE);
   assign quo  = quo_ff;

endmodule

[rtl/q8sj_checker.sv]
// ----------------------------------------------------------------------------
// q8sj_checker: port-level checks for the quad8 evaluator
// Watches the request and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module q8sj_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   req_func,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input q8sj_pkg::q8sj_rsp_type rsp_data
);

   // Reset empties the result register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Hold a stalled result row
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result row changed");

   // A load request produces no row
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_func == q8sj_pkg::FUNC_LOAD) && !rsp_valid
      |=> !rsp_valid)
      else $error("row after load request");

   // No new request while rows of an evaluation remain
   a_busy_rows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.out_node != q8sj_pkg::LAST_NODE) |-> !req_ready)
      else $error("request taken in the middle of an evaluation");

endmodule

bind quad8_shape_jacobian_eval q8sj_checker u_q8sj_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .req_func  (req_if.data.func),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_data  (rsp_if.data)
);
